/* rtl/swv_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window variance package
// Shared widths and configuration register indexes.
// ----------------------------------------------------------------------------
package swv_pkg;
  localparam int CFG_BITS = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH = 1'd1;
  localparam int OUT_BITS = 31;
endpackage

/* rtl/swv_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface swv_stream_if #(parameter int W = 64) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/swv_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module swv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/swv_serial_mul.sv */
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module swv_serial_mul #(
  parameter int A_BITS = 38,
  parameter int B_BITS = 38
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     busy,
  output logic [A_BITS+B_BITS-1:0] prod
);
  localparam int CNT_BITS = $clog2(B_BITS + 1);
  logic [A_BITS+B_BITS-1:0] mcand;
  logic [B_BITS-1:0] mplier;
  logic [CNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CNT_BITS'(B_BITS);
      mcand <= {{B_BITS{1'b0}}, a};
      mplier <= b;
      prod <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* rtl/swv_serial_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swv_serial_div #(
  parameter int N_BITS = 60,
  parameter int D_BITS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [N_BITS-1:0] num,
  input  logic [D_BITS-1:0] den,
  output logic              busy,
  output logic [N_BITS-1:0] quot
);
  localparam int CNT_BITS = $clog2(N_BITS + 1);
  logic [D_BITS:0] rem;
  logic [D_BITS:0] trial;
  logic [CNT_BITS-1:0] count;

  assign trial = {rem[D_BITS-1:0], quot[N_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CNT_BITS'(N_BITS);
      quot <= num;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quot <= {quot[N_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        quot <= {quot[N_BITS-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* rtl/sliding_window_variance_unit.sv */
// ----------------------------------------------------------------------------
// Sliding window variance unit
// Per-channel population variance over the most recent window_size rows.
//
// The input channel carries one row of LANES signed samples, sample_0 in the
// low bits. The output channel carries LANES 31-bit variances, variance_0 in
// the low bits. Configuration writes set window_size (index 0) or row_width
// (index 1) and clear the window; write only while the unit is idle.
// One row is handled at a time. Each lane first reads its oldest sample from
// the window RAM and updates its running sums in states S_READ and S_ACC.
// Then, for each lane in use, a serial multiplier forms S1*S1 and n*S2
// and a restoring divider forms the quotient one bit per cycle; a lane at
// or beyond row_width is skipped and gets a zero variance. The result sits
// in an output register until taken; a stalled receiver holds the unit,
// and no new row is accepted until the result transfers. Reset clears the
// sums, counts and configuration to defaults; the window RAM needs no
// clearing since only entries written since the last clear are read.
// ----------------------------------------------------------------------------
module sliding_window_variance_unit #(
  parameter int MAX_WINDOW = 64,
  parameter int LANES = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  swv_stream_if.sink                  in_stream,
  swv_stream_if.source                out_stream,
  input  logic                        cfg_we,
  input  logic [swv_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [swv_pkg::CFG_BITS-1:0] cfg_data
);
  import swv_pkg::*;

  localparam int POS_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int N_BITS = $clog2(MAX_WINDOW + 1);
  localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ADDR_BITS = $clog2(MAX_WINDOW * LANES) > 0 ? $clog2(MAX_WINDOW * LANES) : 1;
  localparam int SUM_BITS = SAMPLE_BITS + N_BITS;
  localparam int SQ_BITS = 2 * SAMPLE_BITS + N_BITS;
  localparam int MUL_A = SQ_BITS;
  localparam int MUL_B = SUM_BITS;
  localparam int PROD_BITS = MUL_A + MUL_B;
  localparam int DEN_BITS = 2 * N_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MSQ  = 3'd3;
  localparam logic [2:0] S_MN   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [CFG_BITS-1:0] window_size;
  logic [2:0] row_width;
  logic [POS_BITS-1:0] write_position;
  logic [N_BITS-1:0] rows_held;
  logic [N_BITS-1:0] eff_window;
  logic [SUM_BITS-1:0] channel_sum [LANES];
  logic [SQ_BITS-1:0] channel_square_sum [LANES];
  logic [LANES*SAMPLE_BITS-1:0] row;
  logic [LANES*OUT_BITS-1:0] result;
  logic [LANE_BITS-1:0] lane;
  logic full;
  logic [N_BITS-1:0] n_new;
  logic [PROD_BITS-1:0] sq_val;
  logic sq_started;

  logic ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic signed [SAMPLE_BITS-1:0] new_s;
  logic [SUM_BITS-1:0] sum_next;
  logic [SQ_BITS-1:0] sq_next;
  logic [SUM_BITS-1:0] abs_sum;

  logic mul_start;
  logic mul_busy;
  logic div_start;
  logic div_busy;
  logic [MUL_A-1:0] mul_a;
  logic [MUL_B-1:0] mul_b;
  logic [PROD_BITS-1:0] prod;
  logic [PROD_BITS-1:0] quot;
  logic [DEN_BITS-1:0] den;
  logic lane_used;

  always_comb begin
    if (window_size == '0) begin
      eff_window = N_BITS'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      eff_window = N_BITS'(MAX_WINDOW);
    end else begin
      eff_window = N_BITS'(window_size);
    end
  end

  assign full = rows_held >= eff_window;
  assign n_new = full ? rows_held : rows_held + 1'b1;
  assign cur = row[lane*SAMPLE_BITS +: SAMPLE_BITS];
  assign ram_addr = ADDR_BITS'({write_position, lane});
  assign ram_we = (state == S_ACC);
  assign old_s = full ? ram_rdata : '0;
  assign new_s = cur;
  assign sum_next = channel_sum[lane] - SUM_BITS'(old_s) + SUM_BITS'(new_s);
  assign sq_next = channel_square_sum[lane] - SQ_BITS'(old_s * old_s)
                   + SQ_BITS'(new_s * new_s);
  assign abs_sum = channel_sum[lane][SUM_BITS-1] ? -channel_sum[lane] : channel_sum[lane];
  assign den = DEN_BITS'(n_new) * DEN_BITS'(n_new);
  assign lane_used = 32'(lane) < 32'(row_width);

  swv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(1 << ADDR_BITS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(cur),
    .raddr(ram_addr), .rdata(ram_rdata)
  );

  swv_serial_mul #(.A_BITS(MUL_A), .B_BITS(MUL_B)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(prod)
  );

  swv_serial_div #(.N_BITS(PROD_BITS), .D_BITS(DEN_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod - sq_val),
    .den(den), .busy(div_busy), .quot(quot)
  );

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a = MUL_A'(abs_sum);
    mul_b = abs_sum;
    if (state == S_MSQ && lane_used && !sq_started) begin
      mul_start = 1'b1;
    end
    if (state == S_MN) begin
      mul_a = channel_square_sum[lane];
      mul_b = MUL_B'(n_new);
      mul_start = !sq_started;
    end
    if (state == S_DIV && !sq_started) begin
      div_start = 1'b1;
    end
  end

  assign in_stream.ready = (state == S_IDLE) && !cfg_we;
  assign out_stream.valid = (state == S_OUT);
  assign out_stream.data = result;

  // S_READ/S_ACC update the sums of every lane; then per lane in use, S_MSQ runs S1*S1 (launched on
  // entry) and S_MN runs n*S2, then S_DIV divides.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_size <= CFG_BITS'(8);
      row_width <= 3'd4;
      write_position <= '0;
      rows_held <= '0;
      lane <= '0;
      sq_started <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        channel_sum[i] <= '0;
        channel_square_sum[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_ROW_WIDTH)) begin
        if (cfg_index == REG_WINDOW_SIZE) begin
          window_size <= cfg_data;
        end else begin
          row_width <= cfg_data[2:0];
        end
        write_position <= '0;
        rows_held <= '0;
        for (int i = 0; i < LANES; i++) begin
          channel_sum[i] <= '0;
          channel_square_sum[i] <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_stream.valid && in_stream.ready) begin
            row <= in_stream.data;
            lane <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_ACC;
        S_ACC: begin
          channel_sum[lane] <= sum_next;
          channel_square_sum[lane] <= sq_next;
          if (lane == LANE_BITS'(LANES - 1)) begin
            lane <= '0;
            sq_started <= 1'b0;
            state <= S_MSQ;
          end else begin
            lane <= lane + 1'b1;
            state <= S_READ;
          end
        end
        S_MSQ: begin
          if (!lane_used) begin
            result[lane*OUT_BITS +: OUT_BITS] <= '0;
            if (lane == LANE_BITS'(LANES - 1)) begin
              state <= S_OUT;
            end else begin
              lane <= lane + 1'b1;
            end
          end else if (!sq_started) begin
            sq_started <= 1'b1;
          end else if (!mul_busy) begin
            sq_val <= prod;
            state <= S_MN;
            sq_started <= 1'b0;
          end
        end
        S_MN: begin
          if (!sq_started) begin
            sq_started <= 1'b1;
          end else if (!mul_busy) begin
            sq_started <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!sq_started) begin
            sq_started <= 1'b1;
          end else if (!div_busy) begin
            sq_started <= 1'b0;
            result[lane*OUT_BITS +: OUT_BITS] <= quot[OUT_BITS-1:0];
            if (lane == LANE_BITS'(LANES - 1)) begin
              state <= S_OUT;
            end else begin
              lane <= lane + 1'b1;
              state <= S_MSQ;
            end
          end
        end
        S_OUT: begin
          if (out_stream.ready) begin
            if (32'(write_position) + 1 >= 32'(eff_window)) begin
              write_position <= '0;
            end else begin
              write_position <= write_position + 1'b1;
            end
            rows_held <= n_new;
            lane <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
